>>> sv/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared widths, metric codes and the job record for the classification
// metrics block.
// ----------------------------------------------------------------------------
package bcm_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int SUM_W   = COUNT_WIDTH + 1;   // sum of two counts
  localparam int F1_W    = COUNT_WIDTH + 2;   // 2tp + fp + fn
  localparam int LIMBS   = 4;                 // product of four sums
  localparam int PROD_W  = LIMBS * SUM_W;
  localparam int ROOT_W  = PROD_W / 2;
  localparam int XY_W    = 2 * COUNT_WIDTH;
  localparam int DIV_W   = ROOT_W;
  localparam int RATIO_W = FRAC_BITS + 1;
  localparam int MCC_W   = FRAC_BITS + 2;
  localparam int NUM_METRICS = 10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RATIO_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  // metric codes, also the flag bit positions
  typedef enum logic [3:0] {
    M_SENS = 4'd0,
    M_SPEC = 4'd1,
    M_PREC = 4'd2,
    M_NPV  = 4'd3,
    M_FALL = 4'd4,
    M_FDR  = 4'd5,
    M_MISS = 4'd6,
    M_ACC  = 4'd7,
    M_F1   = 4'd8,
    M_MCC  = 4'd9
  } metric_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] tp;
    logic [COUNT_WIDTH-1:0] tn;
    logic [COUNT_WIDTH-1:0] fp;
    logic [COUNT_WIDTH-1:0] fn;
    logic [COUNT_WIDTH-1:0] p;
    logic [COUNT_WIDTH-1:0] n;
    logic [SUM_W-1:0]       tpfp;
    logic [SUM_W-1:0]       tpfn;
    logic [SUM_W-1:0]       tnfp;
    logic [SUM_W-1:0]       tnfn;
    logic [SUM_W-1:0]       acc_num;
    logic [SUM_W-1:0]       acc_den;
    logic [SUM_W-1:0]       f1_num;
    logic [F1_W-1:0]        f1_den;
  } job_t;

endpackage

>>> sv/bcm_front.sv
// ----------------------------------------------------------------------------
// bcm_front
// Forms all sums that the ratios and the Matthews denominator need.
// ----------------------------------------------------------------------------
module bcm_front import bcm_pkg::*; (
  input  logic [COUNT_WIDTH-1:0] true_pos,
  input  logic [COUNT_WIDTH-1:0] true_neg,
  input  logic [COUNT_WIDTH-1:0] false_pos,
  input  logic [COUNT_WIDTH-1:0] false_neg,
  input  logic [COUNT_WIDTH-1:0] actual_pos,
  input  logic [COUNT_WIDTH-1:0] actual_neg,
  output job_t                   job
);

  always_comb begin
    job.tp      = true_pos;
    job.tn      = true_neg;
    job.fp      = false_pos;
    job.fn      = false_neg;
    job.p       = actual_pos;
    job.n       = actual_neg;
    job.tpfp    = SUM_W'(true_pos) + SUM_W'(false_pos);
    job.tpfn    = SUM_W'(true_pos) + SUM_W'(false_neg);
    job.tnfp    = SUM_W'(true_neg) + SUM_W'(false_pos);
    job.tnfn    = SUM_W'(true_neg) + SUM_W'(false_neg);
    job.acc_num = SUM_W'(true_pos) + SUM_W'(true_neg);
    job.acc_den = SUM_W'(actual_pos) + SUM_W'(actual_neg);
    job.f1_num  = {true_pos, 1'b0};
    job.f1_den  = {1'b0, true_pos, 1'b0} + F1_W'(false_pos) + F1_W'(false_neg);
  end

endmodule

>>> sv/bcm_queue.sv
// ----------------------------------------------------------------------------
// bcm_queue
// Short job queue between the front and the sequencer.
// ----------------------------------------------------------------------------
module bcm_queue import bcm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
    next_ptr = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_job;
        wr_ptr_r        <= next_ptr(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> sv/bcm_back.sv
// ----------------------------------------------------------------------------
// bcm_back
// Sequencer: shared 33x33 multiplier for the Matthews products, bit-pair
// square root, and one shared restoring divider for every division.
// ----------------------------------------------------------------------------
module bcm_back import bcm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  input  job_t                   job,
  output logic                   job_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [RATIO_W-1:0]     out_sensitivity,
  output logic [RATIO_W-1:0]     out_specificity,
  output logic [RATIO_W-1:0]     out_precision,
  output logic [RATIO_W-1:0]     out_neg_pred_value,
  output logic [RATIO_W-1:0]     out_fall_out,
  output logic [RATIO_W-1:0]     out_false_disc_rate,
  output logic [RATIO_W-1:0]     out_miss_rate,
  output logic [RATIO_W-1:0]     out_accuracy,
  output logic [RATIO_W-1:0]     out_f1_score,
  output logic signed [MCC_W-1:0] out_matthews_corr,
  output logic [NUM_METRICS-1:0] out_zero_div_flags
);

  localparam int SQ_CNT_W = $clog2(ROOT_W);
  localparam int DV_CNT_W = $clog2(FRAC_BITS);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_X, S_MUL_Y, S_MUL_P, S_SQRT, S_DIV_SET, S_DIV_RUN, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  job_t   job_r;

  // multiplier
  logic [SUM_W-1:0]   mul_a, mul_b, mul_c;
  logic [2*SUM_W-1:0] mul_p;
  logic [XY_W-1:0]    x_r, y_r;
  logic [PROD_W-1:0]  acc_r;
  logic [SUM_W-1:0]   carry_r;
  logic [1:0]         limb_r, fct_r;

  // square root
  logic [ROOT_W+1:0]   sq_rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SQ_CNT_W-1:0] sq_cnt_r;
  logic [ROOT_W+3:0]   sq_sh, sq_trial;
  logic                sq_ge;

  // divider
  metric_t             met_r, met_step;
  logic [DIV_W-1:0]    num_sel, den_sel, div_rem_r, div_den_r;
  logic [FRAC_BITS-1:0] q_r, q_nxt;
  logic [DV_CNT_W-1:0] dv_cnt_r;
  logic [DIV_W:0]      dv_sh;
  logic                dv_ge;
  logic [XY_W-1:0]     mcc_mag;
  logic                mcc_neg, neg_r;

  logic [RATIO_W-1:0]     res_r [NUM_METRICS];
  logic [NUM_METRICS-1:0] flags_r;

  logic                   out_valid_r;
  logic [RATIO_W-1:0]     o_ratio_r [NUM_METRICS-1];
  logic [MCC_W-1:0]       o_mcc_r;
  logic [NUM_METRICS-1:0] o_flags_r;

  logic load_out;

  always_comb begin
    unique case (fct_r)
      2'd0:    mul_b = job_r.tpfn;
      2'd1:    mul_b = job_r.tnfp;
      default: mul_b = job_r.tnfn;
    endcase
    mul_a = acc_r[SUM_W-1:0];
    mul_c = carry_r;
    if (state_r == S_MUL_X) begin
      mul_a = SUM_W'(job_r.tp);
      mul_b = SUM_W'(job_r.tn);
      mul_c = '0;
    end else if (state_r == S_MUL_Y) begin
      mul_a = SUM_W'(job_r.fp);
      mul_b = SUM_W'(job_r.fn);
      mul_c = '0;
    end
    mul_p = {{SUM_W{1'b0}}, mul_a} * {{SUM_W{1'b0}}, mul_b}
          + {{SUM_W{1'b0}}, mul_c};
  end

  assign sq_sh    = {sq_rem_r, acc_r[PROD_W-1 -: 2]};
  assign sq_trial = (ROOT_W+4)'({root_r, 2'b01});
  assign sq_ge    = (sq_sh >= sq_trial);

  assign mcc_neg = (x_r < y_r);
  assign mcc_mag = mcc_neg ? (y_r - x_r) : (x_r - y_r);

  always_comb begin
    unique case (met_r)
      M_SENS:  begin num_sel = DIV_W'(job_r.tp);      den_sel = DIV_W'(job_r.p);       end
      M_SPEC:  begin num_sel = DIV_W'(job_r.tn);      den_sel = DIV_W'(job_r.n);       end
      M_PREC:  begin num_sel = DIV_W'(job_r.tp);      den_sel = DIV_W'(job_r.tpfp);    end
      M_NPV:   begin num_sel = DIV_W'(job_r.tn);      den_sel = DIV_W'(job_r.tnfn);    end
      M_FALL:  begin num_sel = DIV_W'(job_r.fp);      den_sel = DIV_W'(job_r.n);       end
      M_MISS:  begin num_sel = DIV_W'(job_r.fn);      den_sel = DIV_W'(job_r.p);       end
      M_ACC:   begin num_sel = DIV_W'(job_r.acc_num); den_sel = DIV_W'(job_r.acc_den); end
      M_F1:    begin num_sel = DIV_W'(job_r.f1_num);  den_sel = DIV_W'(job_r.f1_den);  end
      M_MCC:   begin num_sel = DIV_W'(mcc_mag);       den_sel = root_r;                end
      default: begin num_sel = '0;                    den_sel = '0;                    end
    endcase
  end

  // false discovery rate comes from precision, so its slot is skipped
  always_comb begin
    unique case (met_r)
      M_FALL:  met_step = M_MISS;
      M_SENS:  met_step = M_SPEC;
      M_SPEC:  met_step = M_PREC;
      M_PREC:  met_step = M_NPV;
      M_NPV:   met_step = M_FALL;
      M_MISS:  met_step = M_ACC;
      M_ACC:   met_step = M_F1;
      M_F1:    met_step = M_MCC;
      default: met_step = M_MCC;
    endcase
  end

  assign dv_sh = {div_rem_r, 1'b0};
  assign dv_ge = (dv_sh >= {1'b0, div_den_r});
  assign q_nxt = {q_r[FRAC_BITS-2:0], dv_ge};

  assign job_pop  = (state_r == S_IDLE) && job_valid;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (job_valid) state_nxt = S_MUL_X;
      S_MUL_X:   state_nxt = S_MUL_Y;
      S_MUL_Y:   state_nxt = S_MUL_P;
      S_MUL_P:   if (limb_r == 2'd3 && fct_r == 2'd2) state_nxt = S_SQRT;
      S_SQRT:    if (sq_cnt_r == SQ_CNT_W'(ROOT_W - 1)) state_nxt = S_DIV_SET;
      S_DIV_SET: begin
        if ((den_sel == '0 || num_sel >= den_sel) && met_r == M_MCC) begin
          state_nxt = S_DONE;
        end else if (den_sel != '0 && num_sel < den_sel) begin
          state_nxt = S_DIV_RUN;
        end
      end
      S_DIV_RUN: begin
        if (dv_cnt_r == DV_CNT_W'(FRAC_BITS - 1)) begin
          state_nxt = (met_r == M_MCC) ? S_DONE : S_DIV_SET;
        end
      end
      S_DONE:    if (load_out) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        job_r   <= job;
        flags_r <= '0;
      end
      S_MUL_X: x_r <= mul_p[XY_W-1:0];
      S_MUL_Y: begin
        y_r     <= mul_p[XY_W-1:0];
        acc_r   <= PROD_W'(job_r.tpfp);
        carry_r <= '0;
        limb_r  <= '0;
        fct_r   <= '0;
      end
      S_MUL_P: begin
        // limb-serial multiply; acc rotates so the limb being multiplied is always at the bottom
        acc_r  <= {mul_p[SUM_W-1:0], acc_r[PROD_W-1:SUM_W]};
        limb_r <= limb_r + 1'b1;
        if (limb_r == 2'd3) begin
          carry_r <= '0;
          fct_r   <= fct_r + 1'b1;
        end else begin
          carry_r <= mul_p[2*SUM_W-1:SUM_W];
        end
        sq_rem_r <= '0;
        root_r   <= '0;
        sq_cnt_r <= '0;
      end
      S_SQRT: begin
        acc_r    <= {acc_r[PROD_W-3:0], 2'b00};
        sq_cnt_r <= sq_cnt_r + 1'b1;
        if (sq_ge) begin
          sq_rem_r <= (ROOT_W+2)'(sq_sh - sq_trial);
          root_r   <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_r <= sq_sh[ROOT_W+1:0];
          root_r   <= {root_r[ROOT_W-2:0], 1'b0};
        end
        met_r <= M_SENS;
      end
      S_DIV_SET: begin
        if (met_r == M_MCC) neg_r <= mcc_neg;
        div_rem_r <= num_sel;
        div_den_r <= den_sel;
        q_r       <= '0;
        dv_cnt_r  <= '0;
        if (den_sel == '0) begin
          flags_r[met_r] <= 1'b1;
          res_r[met_r]   <= '0;
          met_r          <= met_step;
        end else if (num_sel >= den_sel) begin
          res_r[met_r] <= ONE_FX;
          met_r        <= met_step;
        end
      end
      S_DIV_RUN: begin
        div_rem_r <= dv_ge ? DIV_W'(dv_sh - {1'b0, div_den_r}) : dv_sh[DIV_W-1:0];
        q_r       <= q_nxt;
        dv_cnt_r  <= dv_cnt_r + 1'b1;
        if (dv_cnt_r == DV_CNT_W'(FRAC_BITS - 1)) begin
          res_r[met_r] <= {1'b0, q_nxt};
          met_r        <= met_step;
        end
      end
      S_DONE: begin
        if (load_out) begin
          for (int i = 0; i < NUM_METRICS - 1; i++) begin
            o_ratio_r[i] <= res_r[i];
          end
          o_ratio_r[M_FDR] <= flags_r[M_PREC] ? '0 : ONE_FX - res_r[M_PREC];
          o_mcc_r   <= neg_r ? MCC_W'(-{1'b0, res_r[M_MCC]}) : {1'b0, res_r[M_MCC]};
          o_flags_r <= flags_r | (NUM_METRICS'(flags_r[M_PREC]) << M_FDR);
        end
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_sensitivity     = o_ratio_r[M_SENS];
  assign out_specificity     = o_ratio_r[M_SPEC];
  assign out_precision       = o_ratio_r[M_PREC];
  assign out_neg_pred_value  = o_ratio_r[M_NPV];
  assign out_fall_out        = o_ratio_r[M_FALL];
  assign out_false_disc_rate = o_ratio_r[M_FDR];
  assign out_miss_rate       = o_ratio_r[M_MISS];
  assign out_accuracy        = o_ratio_r[M_ACC];
  assign out_f1_score        = o_ratio_r[M_F1];
  assign out_matthews_corr   = o_mcc_r;
  assign out_zero_div_flags  = o_flags_r;

endmodule

>>> sv/binary_classification_metrics.sv
// ----------------------------------------------------------------------------
// binary_classification_metrics
// Ten confusion-matrix ratios in Q1.16 plus per-metric zero-denominator flags.
// ----------------------------------------------------------------------------
// Each transaction carries the six counts of a binary confusion matrix and
// returns one transaction with ten ratios, truncated toward zero and saturated
// at 1.0, and a flag word. Inputs are summed and queued (two entries) by the
// front end, so new counts are taken while the sequencer works and while a
// finished result waits at the output. The sequencer sets throughput and
// works on one item at a time: the two Matthews numerator products, the
// limb-serial product of four sums on one 33x33 multiplier, the bit-pair
// square root, then for each of the nine divisions a setup step plus the
// shared one-bit-per-cycle divider (skipped when the denominator is zero or
// the ratio saturates).
module binary_classification_metrics import bcm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COUNT_WIDTH-1:0]  in_true_pos,
  input  logic [COUNT_WIDTH-1:0]  in_true_neg,
  input  logic [COUNT_WIDTH-1:0]  in_false_pos,
  input  logic [COUNT_WIDTH-1:0]  in_false_neg,
  input  logic [COUNT_WIDTH-1:0]  in_actual_pos,
  input  logic [COUNT_WIDTH-1:0]  in_actual_neg,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [RATIO_W-1:0]      out_sensitivity,
  output logic [RATIO_W-1:0]      out_specificity,
  output logic [RATIO_W-1:0]      out_precision,
  output logic [RATIO_W-1:0]      out_neg_pred_value,
  output logic [RATIO_W-1:0]      out_fall_out,
  output logic [RATIO_W-1:0]      out_false_disc_rate,
  output logic [RATIO_W-1:0]      out_miss_rate,
  output logic [RATIO_W-1:0]      out_accuracy,
  output logic [RATIO_W-1:0]      out_f1_score,
  output logic signed [MCC_W-1:0] out_matthews_corr,
  output logic [NUM_METRICS-1:0]  out_zero_div_flags
);

  job_t front_job, head_job;
  logic q_full, q_empty, q_pop;

  bcm_front u_front (
    .true_pos   (in_true_pos),
    .true_neg   (in_true_neg),
    .false_pos  (in_false_pos),
    .false_neg  (in_false_neg),
    .actual_pos (in_actual_pos),
    .actual_neg (in_actual_neg),
    .job        (front_job)
  );

  assign in_ready = !q_full;

  bcm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid && !q_full),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_job)
  );

  bcm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_valid           (!q_empty),
    .job                 (head_job),
    .job_pop             (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_sensitivity     (out_sensitivity),
    .out_specificity     (out_specificity),
    .out_precision       (out_precision),
    .out_neg_pred_value  (out_neg_pred_value),
    .out_fall_out        (out_fall_out),
    .out_false_disc_rate (out_false_disc_rate),
    .out_miss_rate       (out_miss_rate),
    .out_accuracy        (out_accuracy),
    .out_f1_score        (out_f1_score),
    .out_matthews_corr   (out_matthews_corr),
    .out_zero_div_flags  (out_zero_div_flags)
  );

  a_fdr_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_zero_div_flags[M_FDR] == out_zero_div_flags[M_PREC])
    else $error("fdr flag differs from precision flag");

  a_fdr_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_zero_div_flags[M_PREC]) |->
      (RATIO_W'(out_false_disc_rate + out_precision) == ONE_FX))
    else $error("fdr and precision do not sum to one");

  a_mcc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_div_flags[M_MCC]) |-> out_matthews_corr == '0)
    else $error("mcc nonzero with zero denominator");

  a_sens_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_div_flags[M_SENS]) |-> out_sensitivity == '0)
    else $error("sensitivity nonzero with zero denominator");

endmodule

>>> verif/binary_classification_metrics_tb.sv
// ----------------------------------------------------------------------------
// binary_classification_metrics_tb
// Self-checking bench: random and corner confusion counts go in, each of the
// ten ratios and the flag word coming back is checked against a local model.
// ----------------------------------------------------------------------------
module binary_classification_metrics_tb import bcm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef struct {
    cnt_t tp, tn, fp, fn, p, n;
  } counts_t;

  typedef struct {
    logic [RATIO_W-1:0]      r [9];
    logic signed [MCC_W-1:0] mcc;
    logic [NUM_METRICS-1:0]  flags;
  } metrics_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cnt_t in_true_pos = '0, in_true_neg = '0, in_false_pos = '0;
  cnt_t in_false_neg = '0, in_actual_pos = '0, in_actual_neg = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RATIO_W-1:0] out_sensitivity, out_specificity, out_precision;
  logic [RATIO_W-1:0] out_neg_pred_value, out_fall_out, out_false_disc_rate;
  logic [RATIO_W-1:0] out_miss_rate, out_accuracy, out_f1_score;
  logic signed [MCC_W-1:0] out_matthews_corr;
  logic [NUM_METRICS-1:0] out_zero_div_flags;

  counts_t  pending_counts[$];
  metrics_t expected_metrics[$];
  int n_errors = 0;
  int n_results = 0;
  int n_sent = 0;
  bit stim_done = 1'b0;
  bit drain_hold = 1'b0;

  binary_classification_metrics dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // floor(num * 2^FRAC_BITS / den), saturated at one; zero with its flag set if den is zero
  function automatic logic [RATIO_W-1:0] fx_ratio(logic [63:0] num, logic [63:0] den,
                                                 metric_t m,
                                                 ref logic [NUM_METRICS-1:0] flags);
    logic [127:0] q;
    if (den == 0) begin
      flags[m] = 1'b1;
      return '0;
    end
    if (num >= den) return ONE_FX;
    q = ({64'd0, num} << FRAC_BITS) / den;
    return q[RATIO_W-1:0];
  endfunction

  function automatic logic [127:0] isqrt256(logic [255:0] v);
    logic [127:0] root;
    logic [127:0] cand;
    root = '0;
    for (int i = 127; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if ({128'd0, cand} * {128'd0, cand} <= v) root = cand;
    end
    return root;
  endfunction

  function automatic metrics_t compute_metrics(counts_t c);
    metrics_t m;
    logic [63:0] tp, tn, fp, fn, p, n;
    logic [255:0] prod, x, y, diff, den;
    logic [RATIO_W-1:0] mag;
    bit neg;
    tp = c.tp; tn = c.tn; fp = c.fp; fn = c.fn; p = c.p; n = c.n;
    m.flags = '0;
    m.r[M_SENS] = fx_ratio(tp, p, M_SENS, m.flags);
    m.r[M_SPEC] = fx_ratio(tn, n, M_SPEC, m.flags);
    m.r[M_PREC] = fx_ratio(tp, tp + fp, M_PREC, m.flags);
    m.r[M_NPV]  = fx_ratio(tn, tn + fn, M_NPV, m.flags);
    m.r[M_FALL] = fx_ratio(fp, n, M_FALL, m.flags);
    if (tp + fp == 0) begin
      m.flags[M_FDR] = 1'b1;
      m.r[M_FDR] = '0;
    end else begin
      m.r[M_FDR] = ONE_FX - m.r[M_PREC];
    end
    m.r[M_MISS] = fx_ratio(fn, p, M_MISS, m.flags);
    m.r[M_ACC]  = fx_ratio(tp + tn, p + n, M_ACC, m.flags);
    m.r[M_F1]   = fx_ratio(2 * tp, 2 * tp + fp + fn, M_F1, m.flags);
    prod = 256'(tp + fp) * 256'(tp + fn) * 256'(tn + fp) * 256'(tn + fn);
    den = {128'd0, isqrt256(prod)};
    m.mcc = '0;
    if (den == 0) begin
      m.flags[M_MCC] = 1'b1;
    end else begin
      x = 256'(tp) * 256'(tn);
      y = 256'(fp) * 256'(fn);
      neg = x < y;
      diff = neg ? y - x : x - y;
      if (diff >= den) mag = ONE_FX;
      else mag = RATIO_W'((diff << FRAC_BITS) / den);
      m.mcc = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
    return m;
  endfunction

  function automatic cnt_t rand_count(int mode);
    case (mode)
      0: return cnt_t'($urandom_range(0, 20));
      1: return cnt_t'($urandom_range(0, 5000));
      2: return $urandom;
      default: return '1 - cnt_t'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic counts_t rand_counts();
    counts_t c;
    int mode;
    mode = $urandom_range(0, 9);
    mode = (mode < 3) ? 0 : (mode < 6) ? 1 : (mode < 9) ? 2 : 3;
    c.tp = rand_count(mode); c.tn = rand_count(mode);
    c.fp = rand_count(mode); c.fn = rand_count(mode);
    if ($urandom_range(0, 3) != 0) begin
      // consistent matrix; the sums may wrap at full width
      c.p = c.tp + c.fn;
      c.n = c.tn + c.fp;
    end else begin
      c.p = rand_count($urandom_range(0, 3));
      c.n = rand_count($urandom_range(0, 3));
    end
    return c;
  endfunction

  task automatic send_next();
    counts_t c;
    c = pending_counts.pop_front();
    expected_metrics.push_back(compute_metrics(c));
    in_true_pos <= c.tp; in_true_neg <= c.tn;
    in_false_pos <= c.fp; in_false_neg <= c.fn;
    in_actual_pos <= c.p; in_actual_neg <= c.n;
    in_valid <= 1'b1;
    n_sent++;
  endtask

  // driver
  int tx_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        // zero gap: next transaction follows back to back
        if (tx_gap == 0 && !drain_hold && pending_counts.size() > 0) begin
          send_next();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid && !drain_hold && pending_counts.size() > 0) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else begin
          send_next();
        end
      end
    end
  end

  // monitor
  int rx_wait = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        metrics_t got, exp_m;
        got.r[M_SENS] = out_sensitivity;   got.r[M_SPEC] = out_specificity;
        got.r[M_PREC] = out_precision;     got.r[M_NPV]  = out_neg_pred_value;
        got.r[M_FALL] = out_fall_out;      got.r[M_FDR]  = out_false_disc_rate;
        got.r[M_MISS] = out_miss_rate;     got.r[M_ACC]  = out_accuracy;
        got.r[M_F1]   = out_f1_score;
        got.mcc = out_matthews_corr;
        got.flags = out_zero_div_flags;
        n_results++;
        if (expected_metrics.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR: unexpected transaction at %0t", $realtime);
        end else begin
          exp_m = expected_metrics.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (got.r[k] !== exp_m.r[k]) begin
              n_errors++;
              if (n_errors <= 10)
                $display("ERROR: result %0d metric %0d exp %0d got %0d", n_results,
                         k, exp_m.r[k], got.r[k]);
            end
          end
          if (got.mcc !== exp_m.mcc) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: result %0d MCC exp %0d got %0d", n_results,
                       exp_m.mcc, got.mcc);
          end
          if (got.flags !== exp_m.flags) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: result %0d flags exp %b got %b", n_results,
                       exp_m.flags, got.flags);
          end
        end
        rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        out_ready <= (rx_wait == 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= (rx_wait == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    counts_t c;
    cnt_t mx;
    mx = '1;
    c = '{0, 0, 0, 0, 0, 0};                      pending_counts.push_back(c);
    c = '{mx, mx, mx, mx, mx, mx};                pending_counts.push_back(c);
    c = '{10, 10, 0, 0, 10, 10};                  pending_counts.push_back(c);
    c = '{0, 0, 10, 10, 10, 10};                  pending_counts.push_back(c);
    c = '{5, 0, 0, 0, 5, 0};                      pending_counts.push_back(c);
    c = '{0, 5, 0, 0, 0, 5};                      pending_counts.push_back(c);
    c = '{0, 0, 7, 0, 0, 7};                      pending_counts.push_back(c);
    c = '{0, 0, 0, 7, 7, 0};                      pending_counts.push_back(c);
    c = '{9, 3, 1, 2, 4, 2};                      pending_counts.push_back(c);
    c = '{mx, 1, 0, 0, 1, 1};                     pending_counts.push_back(c);
    c = '{mx, mx, 1, 1, mx, mx};                  pending_counts.push_back(c);
    c = '{3, 7, 2, 5, 8, 9};                      pending_counts.push_back(c);
    c = '{1, 1, mx, mx, mx, mx};                  pending_counts.push_back(c);
    c = '{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
          32'hAAAA_AAAA, 32'h5555_5555};          pending_counts.push_back(c);
    c = '{1, 0, 0, 0, 1, 0};                      pending_counts.push_back(c);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 800; i++) pending_counts.push_back(rand_counts());
    // one full drain partway through
    wait (n_sent >= 300);
    @(posedge clk);
    drain_hold <= 1'b1;
    wait (expected_metrics.size() == 0 && !in_valid);
    @(posedge clk);
    drain_hold <= 1'b0;
    wait (pending_counts.size() == 0);
    wait (!in_valid);
    wait (expected_metrics.size() == 0);
    repeat (300) @(posedge clk);
    $display("Checked %0d metric results from %0d count sets (corners, consistent", n_results,
             n_sent);
    $display("and inconsistent random matrices, full-width counts, random stalls).");
    if (n_errors == 0) begin
      $display("binary_classification_metrics regression: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("binary_classification_metrics regression: fail");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout");
    $display("binary_classification_metrics regression: fail");
    $finish;
  end

endmodule

>>> binary_classification_metrics.f
sv/bcm_pkg.sv
sv/bcm_front.sv
sv/bcm_queue.sv
sv/bcm_back.sv
sv/binary_classification_metrics.sv
verif/binary_classification_metrics_tb.sv
